[rtl/svr_pkg.sv]
// Shared types and constants of the sample voice renderer.
// Holds field widths, register indexes, reset values and the channel payloads.
// No dependencies.
package svr_pkg;

  localparam int POS_FRAC_W = 16;
  localparam int POS_INT_W  = 24;
  localparam int POS_W      = POS_INT_W + POS_FRAC_W;
  localparam int SAMPLE_W   = 16;
  localparam int ENV_W      = 16;
  localparam int COEF_W     = 16;
  localparam int GAIN_W     = 16;
  localparam int STEP_W     = 24;
  localparam int LEN_W      = 24;
  localparam int MIX_W      = 24;
  localparam int PEAK_W     = 23;
  localparam int STATE_W    = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PITCH_STEP    = 3'd0,
    CFG_SAMPLE_LENGTH = 3'd1,
    CFG_FILTER_ON     = 3'd2,
    CFG_CUTOFF        = 3'd3,
    CFG_RESONANCE     = 3'd4,
    CFG_GAIN_LEFT     = 3'd5,
    CFG_GAIN_RIGHT    = 3'd6
  } cfg_idx_e;

  localparam logic [STEP_W-1:0] PITCH_RST  = STEP_W'(65536);
  localparam logic [LEN_W-1:0]  LENGTH_RST = LEN_W'(1);
  localparam logic [COEF_W-1:0] CUTOFF_RST = COEF_W'(65535);
  localparam logic [COEF_W-1:0] RESON_RST  = COEF_W'(0);
  localparam logic [GAIN_W-1:0] GAIN_RST   = GAIN_W'(4096);

  typedef struct packed {
    logic                       note_start;
    logic signed [SAMPLE_W-1:0] left_here;
    logic signed [SAMPLE_W-1:0] right_here;
    logic signed [SAMPLE_W-1:0] left_after;
    logic signed [SAMPLE_W-1:0] right_after;
    logic [ENV_W-1:0]           envelope;
    logic signed [MIX_W-1:0]    mix_in_left;
    logic signed [MIX_W-1:0]    mix_in_right;
    logic                       peak_clear;
  } svr_in_t;

  typedef struct packed {
    logic signed [MIX_W-1:0] mix_out_left;
    logic signed [MIX_W-1:0] mix_out_right;
    logic [PEAK_W-1:0]       peak_left;
    logic [PEAK_W-1:0]       peak_right;
    logic [POS_INT_W-1:0]    fetch_index;
    logic                    done_res;
  } svr_out_t;

endpackage

[rtl/svr_if.sv]
// Valid/ready stream interfaces for the sample voice renderer.
// Depends on svr_pkg for the frame payload types.
interface svr_in_if import svr_pkg::*; ();
  logic    valid;
  logic    ready;
  svr_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface svr_out_if import svr_pkg::*; ();
  logic     valid;
  logic     ready;
  svr_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/sample_voice_renderer_top.sv]
// Stereo sampler voice: microcoded datapath around one shared 33x17 multiplier.
// A silent frame skips the channel steps and a frame with the filter off skips the filter
// steps; the next input is taken only once the result is loaded into the output register,
// so a held result stalls the last step and the next frame with it.
// Reset (rst_ni low, async) clears position, filter state, peaks, done and loads the
// register defaults. Depends on svr_pkg and svr_if.
module sample_voice_renderer_top import svr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  svr_in_if.sink                in_i,
  svr_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int MUL_A_W = STATE_W + 1;
  localparam int MUL_B_W = ((POS_FRAC_W > COEF_W) ? POS_FRAC_W : COEF_W) + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int GAIN_SH = SAMPLE_W - 4;

  localparam logic signed [ACC_W-1:0] RND_POS  = ACC_W'(1) <<< (POS_FRAC_W - 1);
  localparam logic signed [ACC_W-1:0] RND_16   = ACC_W'(1) <<< 15;
  localparam logic signed [ACC_W-1:0] RND_GAIN = ACC_W'(1) <<< (GAIN_SH - 1);

  // Program layout
  localparam int STEP_CW  = 5;
  localparam int PROG_LEN = 25;
  localparam logic [STEP_CW-1:0] ST_CHK   = STEP_CW'(0);
  localparam logic [STEP_CW-1:0] ST_CH0   = STEP_CW'(1);
  localparam logic [STEP_CW-1:0] ST_CH1   = STEP_CW'(12);
  localparam logic [STEP_CW-1:0] ST_POS   = STEP_CW'(23);
  localparam logic [STEP_CW-1:0] ST_OUT   = STEP_CW'(24);
  localparam logic [3:0]         GAIN_OFF = 4'd9;

  typedef enum logic {S_IDLE, S_RUN} state_e;

  typedef enum logic [2:0] {
    K_CHK, K_MUL, K_WB_V, K_WB_BAND, K_WB_LOW, K_WB_VOICE, K_POS, K_OUT
  } kind_e;
  typedef enum logic [1:0] {MA_DIFF, MA_V, MA_BAND, MA_VLOW} mul_a_e;
  typedef enum logic [2:0] {MB_FRAC, MB_ENV, MB_RES, MB_CUT, MB_GAIN} mul_b_e;
  typedef enum logic [1:0] {AD_HERE, AD_RND16, AD_RNDG, AD_ACC} add_e;
  typedef enum logic [1:0] {SH_POS, SH_16, SH_GAIN} shift_e;
  typedef enum logic [1:0] {JC_NONE, JC_SILENT, JC_NOFILT} jump_e;

  typedef struct packed {
    kind_e              kind;
    logic               ch;
    mul_a_e             ma;
    mul_b_e             mb;
    add_e               ad;
    shift_e             sh;
    jump_e              jc;
    logic [STEP_CW-1:0] tgt;
  } ucode_t;

  function automatic ucode_t uc_mul(logic ch, mul_a_e ma, mul_b_e mb, add_e ad);
    ucode_t w;
    w      = '0;
    w.kind = K_MUL;
    w.ch   = ch;
    w.ma   = ma;
    w.mb   = mb;
    w.ad   = ad;
    w.jc   = JC_NONE;
    return w;
  endfunction

  function automatic ucode_t uc_ctl(kind_e kind, logic ch, shift_e sh, jump_e jc,
                                    logic [STEP_CW-1:0] tgt);
    ucode_t w;
    w      = '0;
    w.kind = kind;
    w.ch   = ch;
    w.sh   = sh;
    w.jc   = jc;
    w.tgt  = tgt;
    return w;
  endfunction

  // One channel: interpolate, envelope, optional filter, gain.
  function automatic ucode_t uc_chan(logic ch, logic [3:0] off, logic [STEP_CW-1:0] base);
    ucode_t             w;
    logic [STEP_CW-1:0] gain_step;
    gain_step = base + STEP_CW'(GAIN_OFF);
    case (off)
      4'd0:    w = uc_mul(ch, MA_DIFF, MB_FRAC, AD_HERE);
      4'd1:    w = uc_ctl(K_WB_V, ch, SH_POS, JC_NONE, '0);
      4'd2:    w = uc_mul(ch, MA_V, MB_ENV, AD_RND16);
      4'd3:    w = uc_ctl(K_WB_V, ch, SH_16, JC_NOFILT, gain_step);
      4'd4:    w = uc_mul(ch, MA_BAND, MB_RES, AD_RND16);
      4'd5:    w = uc_mul(ch, MA_VLOW, MB_CUT, AD_ACC);
      4'd6:    w = uc_ctl(K_WB_BAND, ch, SH_16, JC_NONE, '0);
      4'd7:    w = uc_mul(ch, MA_BAND, MB_CUT, AD_RND16);
      4'd8:    w = uc_ctl(K_WB_LOW, ch, SH_16, JC_NONE, '0);
      4'd9:    w = uc_mul(ch, MA_V, MB_GAIN, AD_RNDG);
      4'd10:   w = uc_ctl(K_WB_VOICE, ch, SH_GAIN, JC_NONE, '0);
      default: w = uc_ctl(K_WB_VOICE, ch, SH_GAIN, JC_NONE, '0);
    endcase
    return w;
  endfunction

  function automatic ucode_t ucode_rom(logic [STEP_CW-1:0] step);
    ucode_t w;
    if (step == ST_CHK) begin
      w = uc_ctl(K_CHK, 1'b0, SH_16, JC_SILENT, ST_POS);
    end else if (step < ST_CH1) begin
      w = uc_chan(1'b0, 4'(step - ST_CH0), ST_CH0);
    end else if (step < ST_POS) begin
      w = uc_chan(1'b1, 4'(step - ST_CH1), ST_CH1);
    end else if (step == ST_POS) begin
      w = uc_ctl(K_POS, 1'b0, SH_16, JC_NONE, '0);
    end else begin
      w = uc_ctl(K_OUT, 1'b0, SH_16, JC_NONE, '0);
    end
    return w;
  endfunction

  function automatic logic signed [STATE_W-1:0] sat_w32(logic signed [ACC_W-1:0] x);
    logic hi_ones;
    logic hi_zero;
    hi_ones = &x[ACC_W-1:STATE_W-1];
    hi_zero = ~|x[ACC_W-1:STATE_W-1];
    if (hi_ones || hi_zero) return x[STATE_W-1:0];
    else if (x[ACC_W-1]) return {1'b1, {(STATE_W-1){1'b0}}};
    else return {1'b0, {(STATE_W-1){1'b1}}};
  endfunction

  function automatic logic signed [MIX_W-1:0] sat_w24(logic signed [ACC_W-1:0] x);
    logic hi_ones;
    logic hi_zero;
    hi_ones = &x[ACC_W-1:MIX_W-1];
    hi_zero = ~|x[ACC_W-1:MIX_W-1];
    if (hi_ones || hi_zero) return x[MIX_W-1:0];
    else if (x[ACC_W-1]) return {1'b1, {(MIX_W-1){1'b0}}};
    else return {1'b0, {(MIX_W-1){1'b1}}};
  endfunction

  // Control and architectural state
  state_e              state_q;
  logic [STEP_CW-1:0]  step_q, step_d;
  logic [STEP_W-1:0]   pitch_q;
  logic [LEN_W-1:0]    len_q;
  logic                filter_on_q;
  logic [COEF_W-1:0]   cutoff_q, reson_q;
  logic [GAIN_W-1:0]   gain_l_q, gain_r_q;
  logic [POS_W-1:0]    pos_q;
  logic signed [STATE_W-1:0] band_q [2];
  logic signed [STATE_W-1:0] low_q [2];
  logic [PEAK_W-1:0]   peak_q [2];
  logic                ended_q;
  logic                out_valid_q;
  svr_out_t            out_q;

  // Datapath registers
  svr_in_t                    in_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [MUL_A_W-1:0]  v_q;
  logic signed [MIX_W-1:0]    voice_q [2];
  logic                       active_q;
  logic                       last_q;

  ucode_t                     uw;
  logic                       in_xfer, out_load, jump_taken, active_now;
  logic [POS_INT_W-1:0]       ipos;
  logic                       ch;
  logic signed [SAMPLE_W-1:0] a_here, a_after, b_val;
  logic signed [STATE_W-1:0]  band_cur, low_cur, low_new;
  logic [GAIN_W-1:0]          gain_cur;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    addend, acc_d, shifted, low_sum;
  logic [POS_W:0]             pos_sum;
  logic [POS_W-1:0]           pos_next;
  logic [POS_INT_W-1:0]       fetch_d;
  svr_out_t                   out_d;

  assign uw         = ucode_rom(step_q);
  assign ch         = uw.ch;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
  assign out_load   = (state_q == S_RUN) && (uw.kind == K_OUT) &&
                      (!out_valid_q || out_o.ready);

  assign ipos       = pos_q[POS_W-1:POS_FRAC_W];
  assign active_now = !ended_q && (ipos < len_q);
  assign jump_taken = ((uw.jc == JC_SILENT) && !active_now) ||
                      ((uw.jc == JC_NOFILT) && !filter_on_q);

  always_comb begin
    a_here   = ch ? in_q.right_here : in_q.left_here;
    a_after  = ch ? in_q.right_after : in_q.left_after;
    b_val    = last_q ? '0 : a_after;
    band_cur = band_q[ch];
    low_cur  = low_q[ch];
    gain_cur = ch ? gain_r_q : gain_l_q;

    case (uw.ma)
      MA_DIFF: mul_a = MUL_A_W'(b_val) - MUL_A_W'(a_here);
      MA_V:    mul_a = v_q;
      MA_BAND: mul_a = MUL_A_W'(band_cur);
      MA_VLOW: mul_a = v_q - MUL_A_W'(low_cur);
      default: mul_a = v_q;
    endcase

    case (uw.mb)
      MB_FRAC: mul_b = MUL_B_W'(pos_q[POS_FRAC_W-1:0]);
      MB_ENV:  mul_b = MUL_B_W'(in_q.envelope);
      MB_RES:  mul_b = MUL_B_W'(reson_q);
      MB_CUT:  mul_b = MUL_B_W'(cutoff_q);
      MB_GAIN: mul_b = MUL_B_W'(gain_cur);
      default: mul_b = MUL_B_W'(gain_cur);
    endcase

    prod = mul_a * mul_b;

    case (uw.ad)
      AD_HERE:  addend = (ACC_W'(a_here) <<< POS_FRAC_W) + RND_POS;
      AD_RND16: addend = RND_16;
      AD_RNDG:  addend = RND_GAIN;
      AD_ACC:   addend = acc_q;
      default:  addend = acc_q;
    endcase
    acc_d = ACC_W'(prod) + addend;

    case (uw.sh)
      SH_POS:  shifted = acc_q >>> POS_FRAC_W;
      SH_16:   shifted = acc_q >>> 16;
      SH_GAIN: shifted = acc_q >>> GAIN_SH;
      default: shifted = acc_q >>> 16;
    endcase

    low_sum = ACC_W'(low_cur) + shifted;
    low_new = sat_w32(low_sum);

    // Saturate the position at all ones
    pos_sum  = {1'b0, pos_q} + (POS_W + 1)'(pitch_q);
    pos_next = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];

    if (len_q == '0) fetch_d = '0;
    else if (ipos > len_q - 1'b1) fetch_d = len_q - 1'b1;
    else fetch_d = ipos;

    out_d.mix_out_left  = sat_w24(ACC_W'(in_q.mix_in_left) + ACC_W'(voice_q[0]));
    out_d.mix_out_right = sat_w24(ACC_W'(in_q.mix_in_right) + ACC_W'(voice_q[1]));
    out_d.peak_left     = peak_q[0];
    out_d.peak_right    = peak_q[1];
    out_d.fetch_index   = fetch_d;
    out_d.done_res      = ended_q;

    if (jump_taken) step_d = uw.tgt;
    else step_d = step_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      pitch_q     <= PITCH_RST;
      len_q       <= LENGTH_RST;
      filter_on_q <= 1'b0;
      cutoff_q    <= CUTOFF_RST;
      reson_q     <= RESON_RST;
      gain_l_q    <= GAIN_RST;
      gain_r_q    <= GAIN_RST;
      pos_q       <= '0;
      band_q[0]   <= '0;
      band_q[1]   <= '0;
      low_q[0]    <= '0;
      low_q[1]    <= '0;
      peak_q[0]   <= '0;
      peak_q[1]   <= '0;
      ended_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PITCH_STEP:    pitch_q     <= cfg_wdata_i[STEP_W-1:0];
          CFG_SAMPLE_LENGTH: len_q       <= cfg_wdata_i[LEN_W-1:0];
          CFG_FILTER_ON:     filter_on_q <= cfg_wdata_i[0];
          CFG_CUTOFF:        cutoff_q    <= cfg_wdata_i[COEF_W-1:0];
          CFG_RESONANCE:     reson_q     <= cfg_wdata_i[COEF_W-1:0];
          CFG_GAIN_LEFT:     gain_l_q    <= cfg_wdata_i[GAIN_W-1:0];
          CFG_GAIN_RIGHT:    gain_r_q    <= cfg_wdata_i[GAIN_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
        out_q       <= out_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= S_RUN;
            step_q  <= ST_CHK;
            if (in_i.data.note_start) begin
              pos_q     <= '0;
              band_q[0] <= '0;
              band_q[1] <= '0;
              low_q[0]  <= '0;
              low_q[1]  <= '0;
              ended_q   <= 1'b0;
            end
            if (in_i.data.peak_clear) begin
              peak_q[0] <= '0;
              peak_q[1] <= '0;
            end
          end
        end
        S_RUN: begin
          case (uw.kind)
            K_WB_BAND: band_q[ch] <= sat_w32(shifted);
            K_WB_LOW:  low_q[ch]  <= low_new;
            K_POS: begin
              if (active_q) begin
                pos_q   <= pos_next;
                ended_q <= (pos_next[POS_W-1:POS_FRAC_W] >= len_q);
                if (!voice_q[0][MIX_W-1] && (voice_q[0][PEAK_W-1:0] > peak_q[0]))
                  peak_q[0] <= voice_q[0][PEAK_W-1:0];
                if (!voice_q[1][MIX_W-1] && (voice_q[1][PEAK_W-1:0] > peak_q[1]))
                  peak_q[1] <= voice_q[1][PEAK_W-1:0];
              end else begin
                ended_q <= 1'b1;
              end
            end
            default: ;
          endcase
          // Hold on the final step until the output register is free
          if (uw.kind == K_OUT) begin
            if (out_load) begin
              state_q <= S_IDLE;
              step_q  <= ST_CHK;
            end
          end else begin
            step_q <= step_d;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q       <= in_i.data;
      voice_q[0] <= '0;
      voice_q[1] <= '0;
    end else if (state_q == S_RUN) begin
      case (uw.kind)
        K_CHK: begin
          active_q <= active_now;
          last_q   <= (({1'b0, ipos} + 1'b1) == {1'b0, len_q});
        end
        K_MUL:      acc_q       <= acc_d;
        K_WB_V:     v_q         <= shifted[MUL_A_W-1:0];
        K_WB_LOW:   v_q         <= MUL_A_W'(low_new);
        K_WB_VOICE: voice_q[ch] <= sat_w24(shifted);
        default: ;
      endcase
    end
  end

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (step_q < STEP_CW'(PROG_LEN)))
    else $error("microprogram step out of range");

  a_out_from_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past((state_q == S_RUN) && (uw.kind == K_OUT)))
    else $error("result appeared outside the output step");

  a_fetch_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (len_q != '0)) |-> (fetch_d < len_q))
    else $error("fetch index beyond sample length");

  a_peak_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(in_xfer && in_i.data.peak_clear) |->
      ((peak_q[0] >= $past(peak_q[0])) && (peak_q[1] >= $past(peak_q[1]))))
    else $error("peak hold dropped without a clear");

  a_pos_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(in_xfer && in_i.data.note_start) |-> (pos_q >= $past(pos_q)))
    else $error("position moved backward without a note start");

endmodule
